// ===== design/hrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the hardware-monitor reading converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // sensor type codes
  localparam logic [1:0] MODE_VOLT = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd1;
  localparam logic [1:0] MODE_FAN  = 2'd2;

  // status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  // channel counts per sensor type
  localparam logic [3:0] VOLT_CHANNELS = 4'd9;
  localparam logic [3:0] TEMP_CHANNELS = 4'd3;
  localparam logic [3:0] FAN_CHANNELS  = 4'd3;

  // fan clock dividend and the quotient width it needs
  localparam int QW = 21;
  localparam logic [QW-1:0] FAN_CLOCK = 21'd1350000;

  // special fan count codes
  localparam logic [7:0] FAN_COUNT_STALLED = 8'hFF;
  localparam logic [7:0] FAN_COUNT_NONE    = 8'h00;

  localparam logic [15:0] READING_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] channel;
    logic [7:0] main_byte;
    logic [7:0] low_byte;
    logic [7:0] divisor_high_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] reading;
    logic        status;
  } result_t;

  // data carried down the divider chain
  typedef struct packed {
    logic [7:0]    rem;
    logic [QW-1:0] quo;
    logic [7:0]    divisor;
    logic [2:0]    fan_exp;
    logic          use_div;
    logic [15:0]   reading;
    logic          status;
  } pipe_t;

endpackage

`default_nettype wire

// ===== design/hrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_front
// Decodes one input item: direct readings, fan exponent and divider setup.
// ----------------------------------------------------------------------------
module hrc_front
  import hrc_pkg::*;
(
  input  item_t item,
  output pipe_t pipe
);

  logic [8:0] temp_raw;
  logic       half_bit;
  logic [2:0] fan_exp;

  // temperature: high byte plus half-degree bit, channel 0 has no low byte
  always_comb begin
    half_bit = (item.channel != 4'd0) ? item.low_byte[7] : 1'b0;
    temp_raw = {item.main_byte, half_bit};
  end

  // fan divisor exponent from the per-channel bit fields
  always_comb begin
    unique case (item.channel)
      4'd0:    fan_exp = {item.divisor_high_byte[5], item.low_byte[5:4]};
      4'd1:    fan_exp = {item.divisor_high_byte[6], item.low_byte[7:6]};
      default: fan_exp = {item.divisor_high_byte[7], item.low_byte[7:6]};
    endcase
  end

  // reading select and divider setup
  always_comb begin
    pipe         = '0;
    pipe.divisor = item.main_byte;
    pipe.fan_exp = fan_exp;
    pipe.reading = 16'd0;
    pipe.status  = STATUS_UNSUPPORTED;
    priority if (item.mode == MODE_VOLT && item.channel < VOLT_CHANNELS) begin
      pipe.reading = {8'd0, item.main_byte};
      pipe.status  = STATUS_OK;
    end else if (item.mode == MODE_TEMP && item.channel < TEMP_CHANNELS) begin
      pipe.reading = {{7{temp_raw[8]}}, temp_raw};
      pipe.status  = STATUS_OK;
    end else if (item.mode == MODE_FAN && item.channel < FAN_CHANNELS) begin
      pipe.status = STATUS_OK;
      priority if (item.main_byte == FAN_COUNT_STALLED) begin
        pipe.reading = READING_MAX;
      end else if (item.main_byte == FAN_COUNT_NONE) begin
        pipe.reading = 16'd0;
      end else begin
        pipe.use_div = 1'b1;
      end
    end else begin
      pipe.status = STATUS_UNSUPPORTED;
    end
  end

endmodule

`default_nettype wire

// ===== design/hrc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_div_cell
// One restoring division step: shifts in one dividend bit, yields one
// quotient bit, and registers the result toward the next cell.
// ----------------------------------------------------------------------------
module hrc_div_cell
  import hrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  dividend_bit,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  logic [8:0] trial;
  logic [8:0] diff;
  logic       q_bit;
  pipe_t      step;

  // compare and subtract
  always_comb begin
    trial = {in_data.rem, dividend_bit};
    diff  = trial - {1'b0, in_data.divisor};
    q_bit = (trial >= {1'b0, in_data.divisor});
    step  = in_data;
    step.rem = q_bit ? diff[7:0] : trial[7:0];
    step.quo = {in_data.quo[QW-2:0], q_bit};
  end

  // stage can take a transfer when empty or when its content moves on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule

`default_nettype wire

// ===== design/hrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_back
// Applies the fan exponent shift and saturation, then holds the result in
// the output register.
// ----------------------------------------------------------------------------
module hrc_back
  import hrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  pipe_t   in_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [QW-1:0] scaled;
  result_t       final_res;

  // divide by two to the exponent, then clamp to 16 bits
  always_comb begin
    scaled            = in_data.quo >> in_data.fan_exp;
    final_res.status  = in_data.status;
    final_res.reading = in_data.reading;
    if (in_data.use_div) begin
      if (scaled > {{(QW-16){1'b0}}, READING_MAX}) begin
        final_res.reading = READING_MAX;
      end else begin
        final_res.reading = scaled[15:0];
      end
    end
  end

  assign in_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_ready) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= final_res;
    end
  end

endmodule

`default_nettype wire

// ===== design/hwmon_reading_convert_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwmon_reading_convert_top
// Hardware-monitor reading converter: voltage, temperature and fan readings.
// ----------------------------------------------------------------------------
// Takes one item per cycle when the first cell is ready and returns one
// result per item, in order, after the item has passed 21 restoring division
// cells (one quotient bit each) and the output register. Each cell is its own
// pipeline stage with a local ready, so a stalled output only stops the stages
// that hold data and empty stages keep filling. Fan readings are 1350000 /
// count, shifted right by the divisor exponent and clamped at 65535; other
// readings pass through the same stages unchanged.
// ----------------------------------------------------------------------------
module hwmon_reading_convert_top
  import hrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic  stage_valid [0:QW];
  logic  stage_ready [0:QW];
  pipe_t stage_data  [0:QW];

  // decode feeds the first division cell
  hrc_front u_front (
    .item (item),
    .pipe (stage_data[0])
  );

  assign stage_valid[0] = item_valid;
  assign item_ready     = stage_ready[0];

  // division chain, dividend bits enter msb first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    hrc_div_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .dividend_bit (FAN_CLOCK[QW-1-i]),
      .in_valid     (stage_valid[i]),
      .in_ready     (stage_ready[i]),
      .in_data      (stage_data[i]),
      .out_valid    (stage_valid[i+1]),
      .out_ready    (stage_ready[i+1]),
      .out_data     (stage_data[i+1])
    );
  end

  hrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stage_valid[QW]),
    .in_ready     (stage_ready[QW]),
    .in_data      (stage_data[QW]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // an unsupported request never carries a reading
  a_unsupported_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_UNSUPPORTED |-> result.reading == 16'd0)
    else $error("unsupported result with nonzero reading");

  // input backpressure only when the whole chain is full behind a stalled output
  a_ready_cause : assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled while output side is free");

  // nothing comes out right after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/hwmon_reading_convert_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmon_reading_convert_top_tb
// Self-checking bench for the hardware-monitor reading converter. A directed
// table covers range edges, sign extension, fan special counts and rejected
// modes and channels. A long random run follows. Every result is compared in
// order against a typed result or a local conversion function, with random
// gaps on both sides, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module hwmon_reading_convert_top_tb;
  import hrc_pkg::*;

  // mode code with no sensor type behind it
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int RANDOM_ITEMS   = 750;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  typedef struct {
    item_t   stim;
    logic    typed;
    result_t want;
  } table_row_t;

  table_row_t directed_rows[$];
  result_t    pending_readings[$];
  result_t    oldest;
  int         fail_count;
  int         quiet_cycles;
  logic       rx_enable;
  logic       rx_hold_req;
  logic       rx_steady;
  logic       tx_steady;
  int         rx_hold_left;
  int         rx_gap_left;

  hwmon_reading_convert_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // expected conversion of one item
  function automatic result_t convert_reading(item_t it);
    result_t     r;
    logic [8:0]  half_deg;
    logic [2:0]  div_exp;
    int unsigned divisor;
    int unsigned quo;
    r.reading = '0;
    r.status  = STATUS_UNSUPPORTED;
    case (it.mode)
      MODE_VOLT: begin
        if (it.channel < VOLT_CHANNELS) begin
          r.reading = {8'h00, it.main_byte};
          r.status  = STATUS_OK;
        end
      end
      MODE_TEMP: begin
        if (it.channel < TEMP_CHANNELS) begin
          // channel 0 has no half-degree bit
          half_deg  = {it.main_byte, (it.channel != 4'd0) & it.low_byte[7]};
          r.reading = {{7{half_deg[8]}}, half_deg};
          r.status  = STATUS_OK;
        end
      end
      MODE_FAN: begin
        if (it.channel < FAN_CHANNELS) begin
          case (it.channel)
            4'd0:    div_exp = {it.divisor_high_byte[5], it.low_byte[5:4]};
            4'd1:    div_exp = {it.divisor_high_byte[6], it.low_byte[7:6]};
            default: div_exp = {it.divisor_high_byte[7], it.low_byte[7:6]};
          endcase
          if (it.main_byte == FAN_COUNT_STALLED) begin
            r.reading = READING_MAX;
          end else if (it.main_byte == FAN_COUNT_NONE) begin
            r.reading = '0;
          end else begin
            divisor   = int'(it.main_byte) << div_exp;
            quo       = 32'(FAN_CLOCK) / divisor;
            r.reading = (quo > 32'(READING_MAX)) ? READING_MAX : quo[15:0];
          end
          r.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [1:0] mode, logic [3:0] ch, logic [7:0] mb,
                                    logic [7:0] lb, logic [7:0] hb);
    item_t it;
    it.mode              = mode;
    it.channel           = ch;
    it.main_byte         = mb;
    it.low_byte          = lb;
    it.divisor_high_byte = hb;
    return it;
  endfunction

  function automatic result_t mk_result(logic [15:0] reading, logic status);
    result_t r;
    r.reading = reading;
    r.status  = status;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    sel;
    it.mode              = 2'($urandom_range(0, 3));
    it.low_byte          = 8'($urandom_range(0, 255));
    it.divisor_high_byte = 8'($urandom_range(0, 255));
    // mostly channels the sensor type accepts
    if ($urandom_range(0, 99) < 75) begin
      case (it.mode)
        MODE_VOLT: it.channel = 4'($urandom_range(0, VOLT_CHANNELS - 1));
        MODE_TEMP: it.channel = 4'($urandom_range(0, TEMP_CHANNELS - 1));
        MODE_FAN:  it.channel = 4'($urandom_range(0, FAN_CHANNELS - 1));
        default:   it.channel = 4'($urandom_range(0, 15));
      endcase
    end else begin
      it.channel = 4'($urandom_range(0, 15));
    end
    // lean on the fan special counts and small counts that can saturate
    sel = $urandom_range(0, 9);
    case (sel)
      0:       it.main_byte = FAN_COUNT_NONE;
      1:       it.main_byte = FAN_COUNT_STALLED;
      2:       it.main_byte = 8'($urandom_range(1, 24));
      default: it.main_byte = 8'($urandom_range(0, 255));
    endcase
    return it;
  endfunction

  function automatic void add_row(item_t it, logic typed, result_t want);
    table_row_t row;
    row.stim  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // offer one item and hold it until the transfer; called at a falling edge
  task automatic send_item(item_t it, result_t want);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_readings.push_back(want);
    @(negedge clk);
  endtask

  // output side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (!rx_enable) begin
      result_ready = 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
      result_ready = 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      result_ready = 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      result_ready = 1'b0;
    end else begin
      result_ready = 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_gap_left = pick_gap();
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: reading %h status %b", result.reading, result.status);
        fail_count++;
      end else begin
        oldest = pending_readings.pop_front();
        if (result.reading !== oldest.reading) begin
          $error("reading: expected %h, got %h", oldest.reading, result.reading);
          fail_count++;
        end
        if (result.status !== oldest.status) begin
          $error("status: expected %b, got %b", oldest.status, result.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("hwmon_reading_convert_top_tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    rx_enable    = 1'b0;
    rx_hold_req  = 1'b0;
    rx_steady    = 1'b0;
    tx_steady    = 1'b0;
    rx_hold_left = 0;
    rx_gap_left  = 0;
    fail_count   = 0;
    quiet_cycles = 0;

    // directed table: typed results where obvious, predictor elsewhere
    add_row(mk_item(MODE_VOLT, 4'd0,  8'h00, 8'hFF, 8'hFF), 1'b1, mk_result(16'h0000, STATUS_OK));
    add_row(mk_item(MODE_VOLT, 4'd8,  8'hFF, 8'h00, 8'h00), 1'b1, mk_result(16'h00FF, STATUS_OK));
    add_row(mk_item(MODE_VOLT, 4'd4,  8'hA5, 8'h5A, 8'h00), 1'b0, '0);
    add_row(mk_item(MODE_VOLT, 4'd9,  8'hFF, 8'hFF, 8'hFF), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));
    add_row(mk_item(MODE_VOLT, 4'd15, 8'h12, 8'h00, 8'h00), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));
    add_row(mk_item(MODE_TEMP, 4'd0,  8'hFF, 8'hFF, 8'h00), 1'b1, mk_result(16'hFFFE, STATUS_OK));
    add_row(mk_item(MODE_TEMP, 4'd0,  8'h00, 8'h80, 8'h00), 1'b1, mk_result(16'h0000, STATUS_OK));
    add_row(mk_item(MODE_TEMP, 4'd1,  8'h7F, 8'h80, 8'h00), 1'b1, mk_result(16'h00FF, STATUS_OK));
    add_row(mk_item(MODE_TEMP, 4'd2,  8'h80, 8'h80, 8'hFF), 1'b1, mk_result(16'hFF01, STATUS_OK));
    add_row(mk_item(MODE_TEMP, 4'd2,  8'h19, 8'h7F, 8'h00), 1'b0, '0);
    add_row(mk_item(MODE_TEMP, 4'd3,  8'h40, 8'h80, 8'h00), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));
    add_row(mk_item(MODE_FAN,  4'd0,  8'hFF, 8'h00, 8'h00), 1'b1, mk_result(16'hFFFF, STATUS_OK));
    add_row(mk_item(MODE_FAN,  4'd2,  8'h00, 8'hFF, 8'hFF), 1'b1, mk_result(16'h0000, STATUS_OK));
    add_row(mk_item(MODE_FAN,  4'd0,  8'h01, 8'h00, 8'h00), 1'b1, mk_result(16'hFFFF, STATUS_OK));
    add_row(mk_item(MODE_FAN,  4'd0,  8'h01, 8'h30, 8'h20), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd0,  8'h15, 8'h10, 8'h00), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd1,  8'h14, 8'h40, 8'h00), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd1,  8'h64, 8'h00, 8'h40), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd2,  8'hC8, 8'h40, 8'h00), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd2,  8'hFE, 8'hC0, 8'h80), 1'b0, '0);
    add_row(mk_item(MODE_FAN,  4'd3,  8'h10, 8'h00, 8'h00), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));
    add_row(mk_item(MODE_NONE, 4'd0,  8'h55, 8'h00, 8'h00), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));
    add_row(mk_item(MODE_NONE, 4'd15, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            mk_result(16'h0000, STATUS_UNSUPPORTED));

    // reset
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    rx_enable = 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim,
                directed_rows[i].typed ? directed_rows[i].want
                                       : convert_reading(directed_rows[i].stim));
    end

    // random part with a drain pause, a long output hold-off and steady stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item_t it;
      if (n == 250) begin
        item_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if (n == 400) begin
        item_valid = 1'b0;
        @(posedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
      end
      tx_steady = (n >= 500 && n < 600);
      if (n == 600) begin
        item_valid = 1'b0;
        @(posedge clk);
        rx_steady = 1'b1;
        @(negedge clk);
      end
      if (n == 700) begin
        item_valid = 1'b0;
        @(posedge clk);
        rx_steady = 1'b0;
        @(negedge clk);
      end
      it = random_item();
      send_item(it, convert_reading(it));
    end
    item_valid = 1'b0;

    // drain, then watch for stray results
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d results never arrived", pending_readings.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("hwmon_reading_convert_top_tb: PASS");
    end else begin
      $display("hwmon_reading_convert_top_tb: FAIL");
    end
    $finish;
  end

endmodule
